/* hdl/drlve_pkg.sv */
// ----------------------------------------------------------------------------
// drlve_pkg: deadband run-length vector encoder package
// Shared constants, register index codes and the run flush function.
// ----------------------------------------------------------------------------
package drlve_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int WORD_W    = 32;
   localparam int ADDR_W    = 16;
   localparam int THR_W     = 16;
   localparam int REP_W     = 12;
   localparam int CHAN_W    = 3;
   localparam int VEC_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // The run length is kept as whole thousands plus a remainder below 1000.
   localparam int THOU_W = 11;
   localparam int REM_W  = 10;

   localparam logic [THOU_W-1:0] RUN_THOU_MAX = 11'd1048;
   localparam logic [REM_W-1:0]  RUN_REM_MAX  = 10'd575;
   localparam logic [REM_W-1:0]  REM_TOP      = 10'd999;

   localparam logic [SAMPLE_W-1:0] LEVEL_OFFSET = 16'h8000;
   localparam logic [WORD_W-1:0]   LONG_TAG     = 32'h0400_0000;
   localparam logic [WORD_W-1:0]   LOOP_TAG     = 32'h1000_0000;
   localparam logic [VEC_W-1:0]    VEC_MAX      = 16'hFFFF;
   localparam logic [ADDR_W-1:0]   ADDR_BASE    = 16'h9F20;

   // Result buffer: at most four results per request.
   localparam int BUF_DEPTH = 4;
   localparam int BUF_IDX_W = 2;
   localparam int CNT_W     = 3;
   localparam int CAND_N    = 5;

   // Register index codes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_SELECT = 2'd2;

   typedef struct packed {
      logic              long_vld;
      logic              short_vld;
      logic [WORD_W-1:0] long_word;
      logic [WORD_W-1:0] short_word;
   } flush_type;

   // Turn a finished run into its long and short data vectors.
   function automatic flush_type flush_run(input logic [THOU_W-1:0]   thou,
                                           input logic [REM_W-1:0]    rem,
                                           input logic [SAMPLE_W-1:0] level);
      flush_type            f;
      logic [SAMPLE_W-1:0]  lv;
      logic [THOU_W-1:0]    thou_m1;
      logic [REM_W-1:0]     short_len;
      lv         = level ^ LEVEL_OFFSET;
      thou_m1    = thou - THOU_W'(1);
      // a run of exactly 1000 goes out as one short vector
      short_len  = (rem != '0) ? rem - REM_W'(1) : REM_TOP;
      f.long_vld   = (thou > THOU_W'(1)) || ((thou == THOU_W'(1)) && (rem != '0));
      f.short_vld  = (rem != '0) || (thou == THOU_W'(1));
      f.long_word  = LONG_TAG | {5'd0, thou_m1, lv};
      f.short_word = {6'd0, short_len, lv};
      return f;
   endfunction

endpackage

/* hdl/deadband_run_length_vector_encoder_top.sv */
// ----------------------------------------------------------------------------
// deadband_run_length_vector_encoder_top
// Groups samples that stay within a deadband into runs and writes each run
// out as stimulus vectors, plus a loop vector ending the waveform if the repeat count is above one.
// ----------------------------------------------------------------------------
// A request is one signed 16-bit sample (tlast marks the final sample of the
// waveform). It waits in an input register until the result buffer is free,
// then all of its work (deadband compare, flush of the ended run, flush of
// the final run and the loop vector) is done in a single pass and up to four
// results are loaded into a four-entry result buffer. The result port drains
// that buffer one result per cycle while rsp_tready is high. A request causes
// 0 to 4 results, and the result buffer registers them before the port shows
// them. A new request is taken while the buffer hands out its final entry, so
// requests that cause at most one result each flow at one per cycle while the
// result port does not stall. Registers may be written only while the block is
// idle; writes to an index beyond the list are ignored.
// ----------------------------------------------------------------------------
module deadband_run_length_vector_encoder_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [drlve_pkg::SAMPLE_W-1:0]         req_tdata,   // [15:0] sample
   input  logic                                   req_tlast,   // last_sample
   // result channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [47:0]                            rsp_tdata,   // [15:0] reg_address,
                                                               // [47:16] vector_word
   output logic                                   rsp_tlast,   // last result of this request
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [drlve_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [drlve_pkg::CSR_DAT_W-1:0]        csr_data
);
   import drlve_pkg::*;

   // Configuration registers
   logic [THR_W-1:0]  step_threshold_ff;
   logic [REP_W-1:0]  repeat_count_ff;
   logic [CHAN_W-1:0] channel_select_ff;

   // Input register
   logic                pend_valid_ff, pend_valid_in;
   logic [SAMPLE_W-1:0] pend_sample_ff, pend_sample_in;
   logic                pend_last_ff, pend_last_in;

   // Run state
   logic [SAMPLE_W-1:0] held_level_ff, held_level_in;
   logic [THOU_W-1:0]   run_thou_ff, run_thou_in;
   logic [REM_W-1:0]    run_rem_ff, run_rem_in;
   logic [VEC_W-1:0]    vec_cnt_ff, vec_cnt_in;

   // Result buffer, entry 0 is at the port
   logic [WORD_W-1:0] buf_ff [BUF_DEPTH];
   logic [WORD_W-1:0] buf_in [BUF_DEPTH];
   logic [CNT_W-1:0]  buf_cnt_ff, buf_cnt_in;

   // Single-pass datapath
   logic                process;
   logic                pop;
   logic                buf_free;
   logic signed [SAMPLE_W:0] diff;
   logic [SAMPLE_W:0]   mag;
   logic                change;
   logic                run_sat;
   logic [SAMPLE_W-1:0] held1;
   logic [THOU_W-1:0]   thou1;
   logic [REM_W-1:0]    rem1;
   flush_type           flush_a;
   flush_type           flush_b;
   logic [CNT_W-1:0]    data_cnt;
   logic [VEC_W:0]      vec_sum;
   logic [VEC_W-1:0]    vec_sat;
   logic [WORD_W-1:0]   cand_word [CAND_N];
   logic [CAND_N-1:0]   cand_vld;
   logic [WORD_W-1:0]   pack_word [BUF_DEPTH];
   logic [CNT_W-1:0]    pack_cnt;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (buf_cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   // the buffer can be reloaded once its final entry is leaving
   assign buf_free   = (buf_cnt_ff == '0) || ((buf_cnt_ff == CNT_W'(1)) && pop);
   assign process    = pend_valid_ff && buf_free;
   assign req_tready = !pend_valid_ff || process;

   assign rsp_tlast  = (buf_cnt_ff == CNT_W'(1));
   assign rsp_tdata  = {buf_ff[0], ADDR_BASE + {11'd0, channel_select_ff, 2'b00}};

   // ---------------------------------------------------------------------
   // Deadband compare and run update
   // ---------------------------------------------------------------------
   always_comb begin
      diff    = $signed({pend_sample_ff[SAMPLE_W-1], pend_sample_ff})
              - $signed({held_level_ff[SAMPLE_W-1], held_level_ff});
      mag     = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
      change  = (mag > {1'b0, step_threshold_ff});
      run_sat = (run_thou_ff == RUN_THOU_MAX) && (run_rem_ff == RUN_REM_MAX);

      // flush the ended run before the new level takes over
      flush_a = flush_run(run_thou_ff, run_rem_ff, held_level_ff);

      if (change) begin
         held1 = pend_sample_ff;
         thou1 = '0;
         rem1  = REM_W'(1);
      end else if (run_sat) begin
         held1 = held_level_ff;
         thou1 = run_thou_ff;
         rem1  = run_rem_ff;
      end else if (run_rem_ff == REM_TOP) begin
         held1 = held_level_ff;
         thou1 = run_thou_ff + THOU_W'(1);
         rem1  = '0;
      end else begin
         held1 = held_level_ff;
         thou1 = run_thou_ff;
         rem1  = run_rem_ff + REM_W'(1);
      end

      // flush of the final run on the last sample
      flush_b = flush_run(thou1, rem1, held1);

      cand_vld[0] = change && flush_a.long_vld;
      cand_vld[1] = change && flush_a.short_vld;
      cand_vld[2] = pend_last_ff && flush_b.long_vld;
      cand_vld[3] = pend_last_ff && flush_b.short_vld;
      cand_vld[4] = pend_last_ff && (repeat_count_ff > REP_W'(1));

      data_cnt = CNT_W'(cand_vld[0]) + CNT_W'(cand_vld[1])
               + CNT_W'(cand_vld[2]) + CNT_W'(cand_vld[3]);
      vec_sum  = {1'b0, vec_cnt_ff} + {{(VEC_W-2){1'b0}}, data_cnt};
      vec_sat  = vec_sum[VEC_W] ? VEC_MAX : vec_sum[VEC_W-1:0];

      cand_word[0] = flush_a.long_word;
      cand_word[1] = flush_a.short_word;
      cand_word[2] = flush_b.long_word;
      cand_word[3] = flush_b.short_word;
      cand_word[4] = LOOP_TAG | {4'd0, repeat_count_ff, vec_sat};
   end

   // Pack the valid candidates in order
   always_comb begin
      pack_cnt = '0;
      for (int i = 0; i < BUF_DEPTH; i++) begin
         pack_word[i] = '0;
      end
      for (int i = 0; i < CAND_N; i++) begin
         if (cand_vld[i]) begin
            pack_word[pack_cnt[BUF_IDX_W-1:0]] = cand_word[i];
            pack_cnt = pack_cnt + CNT_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------------
   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_sample_in = pend_sample_ff;
      pend_last_in   = pend_last_ff;
      if (req_tvalid && req_tready) begin
         pend_valid_in  = 1'b1;
         pend_sample_in = req_tdata;
         pend_last_in   = req_tlast;
      end else if (process) begin
         pend_valid_in  = 1'b0;
      end
   end

   always_comb begin
      held_level_in = held_level_ff;
      run_thou_in   = run_thou_ff;
      run_rem_in    = run_rem_ff;
      vec_cnt_in    = vec_cnt_ff;
      if (process) begin
         if (pend_last_ff) begin
            // clear everything for the next waveform
            held_level_in = '0;
            run_thou_in   = '0;
            run_rem_in    = '0;
            vec_cnt_in    = '0;
         end else begin
            held_level_in = held1;
            run_thou_in   = thou1;
            run_rem_in    = rem1;
            vec_cnt_in    = vec_sat;
         end
      end
   end

   always_comb begin
      buf_in     = buf_ff;
      buf_cnt_in = buf_cnt_ff;
      if (process) begin
         buf_in     = pack_word;
         buf_cnt_in = pack_cnt;
      end else if (pop) begin
         // advance the queue towards the port
         for (int i = 0; i < BUF_DEPTH - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         buf_cnt_in = buf_cnt_ff - CNT_W'(1);
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_threshold_ff <= THR_W'(1);
         repeat_count_ff   <= REP_W'(1);
         channel_select_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP_THRESHOLD: step_threshold_ff <= csr_data[THR_W-1:0];
            CSR_REPEAT_COUNT:   repeat_count_ff   <= csr_data[REP_W-1:0];
            CSR_CHANNEL_SELECT: channel_select_ff <= csr_data[CHAN_W-1:0];
            default: begin
               // drop writes outside the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         held_level_ff <= '0;
         run_thou_ff   <= '0;
         run_rem_ff    <= '0;
         vec_cnt_ff    <= '0;
         buf_cnt_ff    <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         held_level_ff <= held_level_in;
         run_thou_ff   <= run_thou_in;
         run_rem_ff    <= run_rem_in;
         vec_cnt_ff    <= vec_cnt_in;
         buf_cnt_ff    <= buf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_sample_ff <= pend_sample_in;
      pend_last_ff   <= pend_last_in;
      buf_ff         <= buf_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      buf_cnt_ff <= CNT_W'(BUF_DEPTH))
      else $error("result buffer count above depth");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      process |-> ((buf_cnt_ff == '0) || ((buf_cnt_ff == CNT_W'(1)) && pop)))
      else $error("result buffer reloaded while results remain");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      run_rem_ff <= REM_TOP)
      else $error("run remainder out of range");

   a_run_sat: assert property (@(posedge clock) disable iff (reset)
      (run_thou_ff < RUN_THOU_MAX) ||
      ((run_thou_ff == RUN_THOU_MAX) && (run_rem_ff <= RUN_REM_MAX)))
      else $error("run length beyond saturation");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (process && pend_last_ff) |=>
      ((run_thou_ff == '0) && (run_rem_ff == '0) && (vec_cnt_ff == '0)))
      else $error("state not cleared after final sample");
`endif

endmodule
